### src/longest_increasing_subsequence_length_assert.svh
// Assertion macros used by the LIS datapath (lis_dp).
// Expects clk and rst_n in the scope of each use.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_ASSERT_SVH

// Invariant checked at every edge outside reset.
`define LIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication checked outside reset.
`define LIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lis_pkg.sv
// Shared types and defaults for the LIS length block.
// No dependencies.
`default_nettype none

package lis_pkg;

    localparam int LIS_MAX_ITEMS   = 1024;
    localparam int LIS_VALUE_WIDTH = 32;
    localparam int VALUE_FIELD_W   = 32;
    localparam int LENGTH_W        = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_PROBE,
        ST_WRITE,
        ST_FINISH
    } lis_state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic probe;
        logic write;
        logic set_ovf;
        logic finish;
    } lis_cmd_t;

    typedef struct packed {
        logic more;
        logic room;
        logic last;
        logic out_free;
    } lis_status_t;

endpackage

`default_nettype wire

### src/lis_ctrl.sv
// Sequencer for the LIS block: accept, binary search, write or drop on overflow, result.
// Depends on lis_pkg.
`default_nettype none

module lis_ctrl
    import lis_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire lis_status_t status,
    output lis_cmd_t         cmd
);

    lis_state_t state_reg;
    lis_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (!status.room)
                begin
                    state_next = status.last ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    state_next = status.more ? ST_PROBE : ST_WRITE;
                end
            end
            ST_PROBE:
            begin
                state_next = status.more ? ST_PROBE : ST_WRITE;
            end
            ST_WRITE:
            begin
                state_next = status.last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready  = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.load   = item_valid;
            end
            ST_START:
            begin
                cmd.start   = status.room;
                cmd.set_ovf = !status.room;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/lis_dp.sv
// Datapath for the LIS block: tails memory, search bounds, counters, result register.
// Depends on lis_pkg and the assertion macro header.
`default_nettype none

`include "longest_increasing_subsequence_length_assert.svh"

module lis_dp
    import lis_pkg::*;
#(
    parameter int MAX_ITEMS   = LIS_MAX_ITEMS,
    parameter int VALUE_WIDTH = LIS_VALUE_WIDTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [VALUE_FIELD_W-1:0] value,
    input  wire logic                     last,
    input  wire lis_cmd_t                 cmd,
    output lis_status_t                   status,
    input  wire logic                     result_ready,
    output logic                          result_valid,
    output logic [LENGTH_W-1:0]           lis_length,
    output logic                          overflow
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(MAX_ITEMS);

    logic [VALUE_WIDTH-1:0] tails_mem [MAX_ITEMS];

    logic [VALUE_WIDTH-1:0] key_reg;
    logic                   last_reg;
    logic [CNT_W-1:0]       best_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   ovf_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [CNT_W-1:0]       mid_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   out_valid_reg;
    logic [LENGTH_W-1:0]    lis_length_reg;
    logic                   overflow_reg;

    logic [VALUE_FIELD_W+VALUE_WIDTH-1:0] value_ext;
    logic [CNT_W+LENGTH_W-1:0]            best_ext;
    logic                                 less;
    logic [CNT_W-1:0]                     cand_lo;
    logic [CNT_W-1:0]                     cand_hi;
    logic [CNT_W-1:0]                     cand_mid;
    logic                                 rd_en;
    logic                                 out_free;

    assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
    assign best_ext  = {{LENGTH_W{1'b0}}, best_reg};
    assign less      = rd_data_reg < key_reg;

    always_comb
    begin
        if (cmd.probe)
        begin
            cand_lo = less ? (mid_reg + CNT_W'(1)) : lo_reg;
            cand_hi = less ? hi_reg : mid_reg;
        end
        else
        begin
            cand_lo = '0;
            cand_hi = best_reg;
        end
        cand_mid = cand_lo + ((cand_hi - cand_lo) >> 1);
    end

    assign rd_en    = (cmd.start || cmd.probe) && (cand_lo < cand_hi);
    assign out_free = !out_valid_reg || result_ready;

    assign status.more     = cand_lo < cand_hi;
    assign status.room     = count_reg < CAPACITY;
    assign status.last     = last_reg;
    assign status.out_free = out_free;

    // tails memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            tails_mem[lo_reg[IDX_W-1:0]] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tails_mem[cand_mid[IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= value_ext[VALUE_WIDTH-1:0] ^ SIGN_FLIP;
        end
        if (cmd.start || cmd.probe)
        begin
            lo_reg  <= cand_lo;
            hi_reg  <= cand_hi;
            mid_reg <= cand_mid;
        end
        if (cmd.finish)
        begin
            lis_length_reg <= best_ext[LENGTH_W-1:0];
            overflow_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            best_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_reg <= last;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.write)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (lo_reg == best_reg)
                begin
                    best_reg <= best_reg + CNT_W'(1);
                end
            end
            if (cmd.finish)
            begin
                best_reg      <= '0;
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign lis_length   = lis_length_reg;
    assign overflow     = overflow_reg;

    `LIS_ASSERT(a_best_le_count, best_reg <= count_reg, "tails length exceeds element count")
    `LIS_ASSERT(a_write_in_range, !cmd.write || (lo_reg <= best_reg), "write beyond tails end")
    `LIS_ASSERT_NEXT(a_finish_clears, cmd.finish, (best_reg == '0) && (count_reg == '0) && result_valid, "sequence state not cleared after result")

endmodule

`default_nettype wire

### src/longest_increasing_subsequence_length.sv
// Longest strictly increasing subsequence length: top level.
// Use: feed signed values on item_valid/item_ready, one beat per element, with last
// set on the final element of a sequence. After that element one beat appears on
// result_valid/result_ready carrying lis_length and overflow; then a new sequence
// starts. Elements beyond MAX_ITEMS in one sequence are dropped and flag overflow.
// Each element passes through accept, search setup, one read of the tails memory per
// binary search step over the current tails length, and write; a new element is
// accepted only once the previous one is through. A dropped element passes through
// accept and the setup step only, which flags overflow. The last element adds a
// finish step that registers the result and raises result_valid.
// A waiting result does not block new elements; only a second result stalls until
// the receiver takes the first one.
// Reset (rst_n, asynchronous, active low) empties the sequence and drops any
// pending result; the tails memory needs no clearing since only entries already
// written in the current sequence are read.
// Depends on lis_pkg, lis_ctrl and lis_dp.
`default_nettype none

module longest_increasing_subsequence_length
    import lis_pkg::*;
#(
    parameter int MAX_ITEMS   = LIS_MAX_ITEMS,
    parameter int VALUE_WIDTH = LIS_VALUE_WIDTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire logic [VALUE_FIELD_W-1:0] value,
    input  wire logic                     last,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic [LENGTH_W-1:0]           lis_length,
    output logic                          overflow
);

    lis_cmd_t    cmd;
    lis_status_t status;

    lis_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    lis_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .last         (last),
        .cmd          (cmd),
        .status       (status),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .lis_length   (lis_length),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire

### sim/longest_increasing_subsequence_length_test.sv
`timescale 1ns / 1ps
// Self-checking bench for longest_increasing_subsequence_length: directed rows and
// random sequences, each result checked against its row value or a tails predictor.
// Depends on lis_pkg and the block's RTL.

module longest_increasing_subsequence_length_test;
    import lis_pkg::*;

    localparam int CAPACITY     = LIS_MAX_ITEMS;
    localparam int IDLE_PCT     = 24;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 525;
    localparam int DIR_COUNT    = 23;
    localparam logic [LIS_VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(LIS_VALUE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [LENGTH_W-1:0] len;
        logic                ovf;
    } lis_result_t;

    typedef struct packed {
        logic [VALUE_FIELD_W-1:0] value;
        logic                     last;
        logic                     known;
        logic [LENGTH_W-1:0]      len;
        logic                     ovf;
    } stim_row_t;

    typedef enum int {
        MODE_WIDE,
        MODE_NARROW,
        MODE_EXTREME,
        MODE_RISING
    } value_mode_t;

    localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
        '{32'h8000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 11'd2, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0005, 1'b1, 1'b1, 11'd1, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b1, 11'd3, 1'b0},
        '{32'h0000_0003, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0002, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0000, 1'b1, 1'b1, 11'd1, 1'b0},
        '{32'h0000_000A, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0014, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_000F, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_001E, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0019, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0028, 1'b1, 1'b0, 11'd0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h5555_5555, 1'b1, 1'b0, 11'd0, 1'b0}
    };

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     item_valid   = 1'b0;
    logic [VALUE_FIELD_W-1:0] value        = '0;
    logic                     last         = 1'b0;
    logic                     result_ready = 1'b0;
    wire                      item_ready;
    wire                      result_valid;
    wire  [LENGTH_W-1:0]      lis_length;
    wire                      overflow;

    // predictor state
    logic [LIS_VALUE_WIDTH-1:0] tail_keys [CAPACITY];
    int unsigned                tail_len    = 0;
    int unsigned                seq_taken   = 0;
    bit                         seq_dropped = 1'b0;

    lis_result_t expected_results [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;

    longest_increasing_subsequence_length dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .lis_length   (lis_length),
        .overflow     (overflow)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
        begin
            $display("ERROR result %0d: %s", results_seen, what);
        end
        mismatches++;
    endtask

    function automatic void lis_absorb(input logic [VALUE_FIELD_W-1:0] v, input logic l,
                                       output bit done, output lis_result_t res);
        logic [LIS_VALUE_WIDTH-1:0] key;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        key  = v[LIS_VALUE_WIDTH-1:0] ^ SIGN_FLIP;
        done = 1'b0;
        res  = '0;
        if (seq_taken < CAPACITY)
        begin
            lo = 0;
            hi = tail_len;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (tail_keys[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid;
            end
            if (lo < CAPACITY)
            begin
                tail_keys[lo] = key;
                if (lo == tail_len)
                    tail_len++;
            end
            seq_taken++;
        end
        else
        begin
            seq_dropped = 1'b1;
        end
        if (l)
        begin
            done        = 1'b1;
            res.len     = tail_len[LENGTH_W-1:0];
            res.ovf     = seq_dropped;
            tail_len    = 0;
            seq_taken   = 0;
            seq_dropped = 1'b0;
        end
    endfunction

    function automatic logic [VALUE_FIELD_W-1:0] pick_value(input value_mode_t mode,
                                                             input int unsigned pos);
        case (mode)
            MODE_WIDE:   return $urandom;
            MODE_NARROW: return 32'($urandom_range(8)) - 32'd4;
            MODE_EXTREME:
            begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:     return 32'(pos * 16) + 32'($urandom_range(40)) - 32'd20;
        endcase
    endfunction

    task automatic send_item(input logic [VALUE_FIELD_W-1:0] v, input logic l,
                             input logic known, input lis_result_t typed);
        bit          done;
        lis_result_t res;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= l;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        lis_absorb(v, l, done, res);
        if (done)
            expected_results.push_back(known ? typed : res);
    endtask

    task automatic check_result(input logic [LENGTH_W-1:0] got_len, input logic got_ovf);
        lis_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected beat, length %0d overflow %0b",
                                      got_len, got_ovf));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got_len !== want.len)
                report_mismatch($sformatf("lis_length %0d, want %0d", got_len, want.len));
            if (got_ovf !== want.ovf)
                report_mismatch($sformatf("overflow %0b, want %0b", got_ovf, want.ovf));
        end
        results_seen++;
    endtask

    // receiver: random back-pressure plus one long hold-off
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                check_result(lis_length, overflow);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        int unsigned    idx;
        int unsigned    k;
        int unsigned    seq_len;
        int unsigned    rand_items;
        bit             held;
        bit             paused;
        value_mode_t    mode;
        lis_result_t    typed;
        rand_items = 0;
        held       = 1'b0;
        paused     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < DIR_COUNT; idx++)
        begin
            typed.len = DIR_ROWS[idx].len;
            typed.ovf = DIR_ROWS[idx].ovf;
            send_item(DIR_ROWS[idx].value, DIR_ROWS[idx].last, DIR_ROWS[idx].known, typed);
        end

        while (rand_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(19) == 0)
                seq_len = $urandom_range(60, 13);
            else
                seq_len = $urandom_range(12, 1);
            mode = value_mode_t'($urandom_range(3));
            for (k = 0; k < seq_len; k++)
                send_item(pick_value(mode, k), k == seq_len - 1, 1'b0, typed);
            rand_items += seq_len;
            if (!held && rand_items >= 150)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            calm = (rand_items >= 300 && rand_items < 420);
            if (!paused && rand_items >= 460)
            begin
                item_valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("longest_increasing_subsequence_length: match");
        else
            $display("longest_increasing_subsequence_length: mismatch");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("longest_increasing_subsequence_length: mismatch");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/lis_pkg.sv
src/lis_ctrl.sv
src/lis_dp.sv
src/longest_increasing_subsequence_length.sv
sim/longest_increasing_subsequence_length_test.sv
